/* hw/rtl/msmk_pkg.sv */
// Shared widths, types and codes of the softening kernel evaluator.
package msmk_pkg;

    localparam int NCOEF = 5;      // configured polynomial coefficients
    localparam int CW    = 32;     // coefficient and result width
    localparam int PW    = 32;     // position width, unsigned Q16.16
    localparam int XW    = 16;     // fraction bits, also position bits below one
    localparam int AW    = 40;     // Horner accumulator width
    localparam int GW    = 52;     // gamma and slope before combining
    localparam int VW    = 56;     // combined result before saturation
    localparam int DW    = 64;     // divider dividend and divisor width
    localparam int QW    = 49;     // divider quotient width (one bit a stage)
    localparam int IDXW  = 3;      // config register index width
    localparam int LANES = 4;      // reciprocals formed per word

    typedef enum logic [1:0] {
        OP_GAMMA = 2'd0,
        OP_THETA = 2'd1,
        OP_TSTAR = 2'd2
    } t_op;

    typedef logic [NCOEF-1:0][CW-1:0] t_coefs;

    // word context that rides alongside the reciprocal divider
    typedef struct packed {
        logic [1:0]           op;
        logic                 p_zero;
        logic                 ge1;    // x at or above one
        logic                 ge2;    // x/2 at or above one
        logic signed [AW-1:0] f1;
        logic signed [AW-1:0] d1;
        logic signed [AW-1:0] f2;
        logic signed [AW-1:0] d2;
    } t_side;

endpackage

/* hw/rtl/msm_softening_kernel_eval_unit.sv */
// Softening kernel evaluator top level: gamma, theta and theta-star with slopes.
//
// Takes one word (opcode, position x in unsigned Q16.16) per cycle and returns
// one word (value, slope, overflow) per input, in order, in signed Q16.16.
// Throughput is one word per clock while the output is not held. The stages
// are, in order: the x-squared and Horner stages, the squaring of the position,
// the bit-per-stage reciprocal divider that forms 1/x and 1/x^2, a register to
// combine the selected function and saturation in the output register.
// The whole pipeline freezes while a finished word waits at the output, so a
// stall drops or repeats nothing. Coefficients are written through the plain
// write port (index 0..4, higher indexes ignored) and must only change while
// no word is in flight.
module msm_softening_kernel_eval_unit import msmk_pkg::*; #(
    parameter int DEGREE = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_opcode,
    input  logic [PW-1:0]        i_position,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [CW-1:0] o_value,
    output logic signed [CW-1:0] o_slope,
    output logic                 o_overflow,
    input  logic                 i_cfg_we,
    input  logic [IDXW-1:0]      i_cfg_idx,
    input  logic [CW-1:0]        i_cfg_wdata
);

    localparam int SBW = $bits(t_side);
    localparam logic signed [VW-1:0] MAXV = VW'(32'sh7FFF_FFFF);
    localparam logic signed [VW-1:0] MINV = VW'(32'sh8000_0000);

    t_coefs r_coef;
    logic   r_out_valid;

    // global advance: everything moves unless the output word is held
    logic w_adv;
    assign w_adv   = !r_out_valid || i_ready;
    assign o_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
        end else if (i_cfg_we && (i_cfg_idx < IDXW'(NCOEF))) begin
            r_coef[i_cfg_idx] <= i_cfg_wdata;
        end
    end

    // Horner lanes for gamma(x) and gamma(x/2); only used below one
    logic signed [AW-1:0] w_f1, w_d1, w_f2, w_d2;

    msmk_poly #(.DEGREE(DEGREE)) u_poly1 (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_x    (i_position[XW-1:0]),
        .i_coef (r_coef),
        .o_f    (w_f1),
        .o_df   (w_d1)
    );

    msmk_poly #(.DEGREE(DEGREE)) u_poly2 (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_x    (i_position[XW:1]),
        .i_coef (r_coef),
        .o_f    (w_f2),
        .o_df   (w_d2)
    );

    // opcode and position follow the lanes
    logic          r_dv  [0:DEGREE];
    logic [1:0]    r_dop [0:DEGREE];
    logic [PW-1:0] r_dp  [0:DEGREE];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DEGREE; k++) r_dv[k] <= 1'b0;
        end else if (w_adv) begin
            r_dv[0] <= i_valid;
            for (int k = 1; k <= DEGREE; k++) r_dv[k] <= r_dv[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dop[0] <= i_opcode;
            r_dp[0]  <= i_position;
            for (int k = 1; k <= DEGREE; k++) begin
                r_dop[k] <= r_dop[k-1];
                r_dp[k]  <= r_dp[k-1];
            end
        end
    end

    // square stage: p^2 and (p/2)^2 as divisors for 1/x^2
    logic                 r_m_valid;
    logic [1:0]           r_m_op;
    logic [PW-1:0]        r_m_p;
    logic [DW-1:0]        r_m_q1, r_m_q2;
    logic signed [AW-1:0] r_m_f1, r_m_d1, r_m_f2, r_m_d2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_adv) begin
            r_m_valid <= r_dv[DEGREE];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m_op <= r_dop[DEGREE];
            r_m_p  <= r_dp[DEGREE];
            r_m_q1 <= DW'(r_dp[DEGREE]) * DW'(r_dp[DEGREE]);
            r_m_q2 <= DW'(r_dp[DEGREE][PW-1:1]) * DW'(r_dp[DEGREE][PW-1:1]);
            r_m_f1 <= w_f1;
            r_m_d1 <= w_d1;
            r_m_f2 <= w_f2;
            r_m_d2 <= w_d2;
        end
    end

    // reciprocals, rounded to nearest: (2^32 + p/2)/p and (2^48 + q/2)/q
    logic [LANES-1:0][DW-1:0] w_num, w_den;
    logic [PW-2:0]            w_p2;
    t_side                    w_side, w_so;
    logic                     w_dv;
    logic [LANES-1:0][QW-1:0] w_quo;

    assign w_p2     = r_m_p[PW-1:1];
    assign w_num[0] = (DW'(1) << 32) + DW'(r_m_p[PW-1:1]);
    assign w_den[0] = DW'(r_m_p);
    assign w_num[1] = (DW'(1) << 32) + DW'(w_p2[PW-2:1]);
    assign w_den[1] = DW'(w_p2);
    assign w_num[2] = (DW'(1) << 48) + (r_m_q1 >> 1);
    assign w_den[2] = r_m_q1;
    assign w_num[3] = (DW'(1) << 48) + (r_m_q2 >> 1);
    assign w_den[3] = r_m_q2;

    assign w_side.op     = r_m_op;
    assign w_side.p_zero = (r_m_p == '0);
    assign w_side.ge1    = (r_m_p[PW-1:XW] != '0);
    assign w_side.ge2    = (r_m_p[PW-1:XW+1] != '0);
    assign w_side.f1     = r_m_f1;
    assign w_side.d1     = r_m_d1;
    assign w_side.f2     = r_m_f2;
    assign w_side.d2     = r_m_d2;

    msmk_div #(.SBW(SBW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_m_valid),
        .i_num   (w_num),
        .i_den   (w_den),
        .i_side  (w_side),
        .o_valid (w_dv),
        .o_quo   (w_quo),
        .o_side  (w_so)
    );

    // combine: pick gamma per range, then form the selected function
    logic signed [GW-1:0] w_inv1, w_inv2, w_isq1, w_isq2;
    logic signed [GW-1:0] w_g1, w_g2, w_s1, w_s2;
    logic signed [VW-1:0] w_tv, w_ts;
    logic signed [VW-1:0] n_c_v, n_c_s;
    logic                 r_c_valid;
    logic signed [VW-1:0] r_c_v, r_c_s;

    assign w_inv1 = GW'($signed({1'b0, w_quo[0]}));
    assign w_inv2 = GW'($signed({1'b0, w_quo[1]}));
    assign w_isq1 = GW'($signed({1'b0, w_quo[2]}));
    assign w_isq2 = GW'($signed({1'b0, w_quo[3]}));
    assign w_g1   = w_so.ge1 ? w_inv1 : GW'(w_so.f1);
    assign w_s1   = w_so.ge1 ? -w_isq1 : GW'(w_so.d1);
    assign w_g2   = w_so.ge2 ? w_inv2 : GW'(w_so.f2);
    assign w_s2   = w_so.ge2 ? -w_isq2 : GW'(w_so.d2);
    assign w_tv   = (VW'(w_g1) <<< 1) - VW'(w_g2);
    assign w_ts   = (VW'(w_s1) <<< 2) - VW'(w_s2);

    always_comb begin
        n_c_v = '0;
        n_c_s = '0;
        case (w_so.op)
            OP_GAMMA: begin
                n_c_v = VW'(w_g1);
                n_c_s = VW'(w_s1);
            end
            OP_THETA: begin
                n_c_v = (w_tv + VW'(1)) >>> 1;
                n_c_s = (w_ts + VW'(2)) >>> 2;
            end
            OP_TSTAR: begin
                if (w_so.p_zero) begin
                    // 1/0: force both to saturate
                    n_c_v = MAXV + VW'(1);
                    n_c_s = MINV - VW'(1);
                end else begin
                    n_c_v = VW'(w_inv1) - VW'(w_g1);
                    n_c_s = -VW'(w_isq1) - VW'(w_s1);
                end
            end
            default: begin
                n_c_v = '0;
                n_c_s = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_adv) begin
            r_c_valid <= w_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c_v <= n_c_v;
            r_c_s <= n_c_s;
        end
    end

    // saturation into the output register
    logic signed [CW-1:0] r_out_value, r_out_slope;
    logic                 r_out_ovf;
    logic signed [CW-1:0] n_value, n_slope;
    logic                 n_ovf;

    always_comb begin
        n_ovf = 1'b0;
        if (r_c_v > MAXV) begin
            n_value = CW'(MAXV);
            n_ovf   = 1'b1;
        end else if (r_c_v < MINV) begin
            n_value = CW'(MINV);
            n_ovf   = 1'b1;
        end else begin
            n_value = CW'(r_c_v);
        end
        if (r_c_s > MAXV) begin
            n_slope = CW'(MAXV);
            n_ovf   = 1'b1;
        end else if (r_c_s < MINV) begin
            n_slope = CW'(MINV);
            n_ovf   = 1'b1;
        end else begin
            n_slope = CW'(r_c_s);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_value <= n_value;
            r_out_slope <= n_slope;
            r_out_ovf   <= n_ovf;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_value    = r_out_value;
    assign o_slope    = r_out_slope;
    assign o_overflow = r_out_ovf;

endmodule

/* hw/rtl/msmk_poly.sv */
// One pipelined Horner lane: even polynomial in x and its derivative.
module msmk_poly import msmk_pkg::*; #(
    parameter int DEGREE = 4
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [XW-1:0]        i_x,
    input  t_coefs               i_coef,
    output logic signed [AW-1:0] o_f,
    output logic signed [AW-1:0] o_df
);

    localparam int MW = AW + XW + 2;

    logic [XW-1:0]        r_x  [0:DEGREE-1];
    logic [XW:0]          r_xx [0:DEGREE-1];
    logic signed [AW-1:0] r_a  [1:DEGREE];
    logic signed [AW-1:0] r_d  [1:DEGREE];
    logic [2*XW:0]        w_sq;
    logic signed [AW-1:0] w_a0;
    logic signed [AW-1:0] w_d0;

    assign w_sq = {1'b0, i_x} * {1'b0, i_x} + (2*XW+1)'(1 << (XW-1));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]  <= i_x;
            r_xx[0] <= w_sq[2*XW:XW];
        end
    end

    // leading coefficient seeds both accumulators
    if (DEGREE < NCOEF) begin : g_lead
        assign w_a0 = AW'($signed(i_coef[DEGREE]));
        assign w_d0 = AW'($signed(i_coef[DEGREE])) * AW'(2*DEGREE);
    end else begin : g_lead_zero
        assign w_a0 = '0;
        assign w_d0 = '0;
    end

    for (genvar k = 1; k <= DEGREE; k++) begin : g_step
        localparam int CI = DEGREE - k;
        logic signed [AW-1:0] w_ain, w_din, w_c, w_ra, w_rd, n_a, n_d;
        logic signed [XW+1:0] w_m;
        logic signed [MW-1:0] w_pa, w_pd;

        if (k == 1) begin : g_first
            assign w_ain = w_a0;
            assign w_din = w_d0;
        end else begin : g_next
            assign w_ain = r_a[k-1];
            assign w_din = r_d[k-1];
        end

        if (CI < NCOEF) begin : g_coef
            assign w_c = AW'($signed(i_coef[CI]));
        end else begin : g_coef_zero
            assign w_c = '0;
        end

        // last step scales the slope by x, the others by x squared
        assign w_m  = (k < DEGREE) ? $signed({1'b0, r_xx[k-1]})
                                   : $signed({2'b00, r_x[k-1]});
        assign w_pa = w_ain * $signed({1'b0, r_xx[k-1]});
        assign w_pd = w_din * w_m;
        assign w_ra = AW'((w_pa + MW'(1 << (XW-1))) >>> XW);
        assign w_rd = AW'((w_pd + MW'(1 << (XW-1))) >>> XW);
        assign n_a  = w_ra + w_c;
        assign n_d  = (k < DEGREE) ? (w_rd + w_c * AW'(2*CI)) : w_rd;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a[k] <= n_a;
                r_d[k] <= n_d;
            end
        end

        if (k < DEGREE) begin : g_pass
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[k]  <= r_x[k-1];
                    r_xx[k] <= r_xx[k-1];
                end
            end
        end
    end

    assign o_f  = r_a[DEGREE];
    assign o_df = r_d[DEGREE];

endmodule

/* hw/rtl/msmk_div.sv */
// Pipelined restoring divider, several lanes, one quotient bit per stage.
module msmk_div import msmk_pkg::*; #(
    parameter int SBW = 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [LANES-1:0][DW-1:0]     i_num,
    input  logic [LANES-1:0][DW-1:0]     i_den,
    input  logic [SBW-1:0]               i_side,
    output logic                         o_valid,
    output logic [LANES-1:0][QW-1:0]     o_quo,
    output logic [SBW-1:0]               o_side
);

    logic                        r_v   [0:QW-1];
    logic [LANES-1:0][DW-1:0]    r_rem [0:QW-1];
    logic [LANES-1:0][QW-1:0]    r_num [0:QW-1];
    logic [LANES-1:0][DW-1:0]    r_den [0:QW-1];
    logic [LANES-1:0][QW-1:0]    r_quo [0:QW-1];
    logic [SBW-1:0]              r_sb  [0:QW-1];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic [LANES-1:0][DW-1:0] w_rin, w_den, n_rem;
        logic [LANES-1:0][QW-1:0] w_nin, w_qin, n_quo;
        logic [LANES-1:0][DW:0]   w_t;
        logic                     w_vin;
        logic [SBW-1:0]           w_sin;

        if (j == 0) begin : g_first
            // quotient fits QW bits, so the top dividend bits start as remainder
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    w_rin[l] = DW'(i_num[l][DW-1:QW]);
                    w_nin[l] = i_num[l][QW-1:0];
                end
            end
            assign w_den = i_den;
            assign w_qin = '0;
            assign w_vin = i_valid;
            assign w_sin = i_side;
        end else begin : g_next
            assign w_rin = r_rem[j-1];
            assign w_nin = r_num[j-1];
            assign w_den = r_den[j-1];
            assign w_qin = r_quo[j-1];
            assign w_vin = r_v[j-1];
            assign w_sin = r_sb[j-1];
        end

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                w_t[l] = {w_rin[l], w_nin[l][QW-1-j]};
                if (w_t[l] >= {1'b0, w_den[l]}) begin
                    n_rem[l] = DW'(w_t[l] - {1'b0, w_den[l]});
                    n_quo[l] = {w_qin[l][QW-2:0], 1'b1};
                end else begin
                    n_rem[l] = w_t[l][DW-1:0];
                    n_quo[l] = {w_qin[l][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= n_rem;
                r_num[j] <= w_nin;
                r_den[j] <= w_den;
                r_quo[j] <= n_quo;
                r_sb[j]  <= w_sin;
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_side  = r_sb[QW-1];

endmodule
